/* hdl/lge_pkg.sv */
package lge_pkg;

    // Wide enough for any board dimension up to 4096 plus a small offset
    localparam int DIM_W = 13;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 128;

    localparam logic [8:0] COLS_RESET = 9'd140;
    localparam logic [7:0] ROWS_RESET = 8'd70;

    localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(3);

    // request commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // configuration register indexes
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_CELL,
        WR_ROW
    } t_wr_src;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_VALUE,
        RES_RDBIT
    } t_res_kind;

    typedef struct packed {
        logic             rd_en;
        logic [DIM_W-1:0] rd_addr;
        logic             wr_en;
        logic [DIM_W-1:0] wr_addr;
        t_wr_src          wr_src;
        logic             row_shift;
        logic             scan;
        logic             upd;
        logic [7:0]       col;
        logic             value;
        logic             out_load;
        logic             out_err;
        t_res_kind        res_kind;
    } t_dp_ctrl;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

/* hdl/lge_ctrl.sv */
module lge_ctrl
    import lge_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    input  logic [1:0]       i_cmd,
    input  logic [6:0]       i_row,
    input  logic [7:0]       i_col,
    input  logic             i_value,
    input  logic [DIM_W-1:0] i_eff_cols,
    input  logic [DIM_W-1:0] i_eff_rows,
    output t_dp_ctrl         o_ctrl,
    input  t_dp_stat         i_stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CELL,
        S_G_R1,
        S_G_R2,
        S_G_LOAD,
        S_SCAN,
        S_G_WRITE,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_cnt, n_cnt;
    logic [DIM_W-1:0] r_col_cnt, n_col_cnt;
    logic [1:0]       r_cmd, n_cmd;
    logic [6:0]       r_row, n_row;
    logic [7:0]       r_col, n_col;
    logic             r_value, n_value;
    t_res_kind        r_res_kind, n_res_kind;
    logic             r_res_err, n_res_err;
    logic [DIM_W-1:0] row_ext;
    logic [DIM_W-1:0] col_ext;

    assign row_ext   = DIM_W'(r_row);
    assign col_ext   = DIM_W'(r_col);
    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_col_cnt  = r_col_cnt;
        n_cmd      = r_cmd;
        n_row      = r_row;
        n_col      = r_col;
        n_value    = r_value;
        n_res_kind = r_res_kind;
        n_res_err  = r_res_err;

        o_ctrl          = '0;
        o_ctrl.wr_src   = WR_CLEAR;
        o_ctrl.col      = r_col;
        o_ctrl.value    = r_value;
        o_ctrl.res_kind = r_res_kind;
        o_ctrl.out_err  = r_res_err;

        unique case (r_state)
            S_CLEAR: begin
                o_ctrl.wr_en   = 1'b1;
                o_ctrl.wr_addr = r_cnt;
                if (r_cnt == DIM_W'(MAX_ROWS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + DIM_W'(1);
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    n_cmd   = i_cmd;
                    n_row   = i_row;
                    n_col   = i_col;
                    n_value = i_value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_kind = RES_ZERO;
                n_res_err  = 1'b0;
                case (r_cmd) inside
                    CMD_ADVANCE: begin
                        if (i_eff_cols < MIN_DIM || i_eff_rows < MIN_DIM) begin
                            n_state = S_FINISH;
                        end else begin
                            o_ctrl.rd_en   = 1'b1;
                            o_ctrl.rd_addr = '0;
                            n_cnt          = DIM_W'(1);
                            n_state        = S_G_R1;
                        end
                    end
                    CMD_WRITE, CMD_READ: begin
                        if (row_ext >= i_eff_rows || col_ext >= i_eff_cols) begin
                            n_res_err = 1'b1;
                            n_state   = S_FINISH;
                        end else begin
                            o_ctrl.rd_en   = 1'b1;
                            o_ctrl.rd_addr = row_ext;
                            n_state        = S_CELL;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_CELL: begin
                // row word is in the read register now
                if (r_cmd == CMD_WRITE) begin
                    o_ctrl.wr_en   = 1'b1;
                    o_ctrl.wr_addr = row_ext;
                    o_ctrl.wr_src  = WR_CELL;
                    n_res_kind     = RES_VALUE;
                end else begin
                    n_res_kind = RES_RDBIT;
                end
                n_state = S_FINISH;
            end
            S_G_R1: begin
                o_ctrl.rd_en     = 1'b1;
                o_ctrl.rd_addr   = DIM_W'(1);
                o_ctrl.row_shift = 1'b1;
                n_state          = S_G_R2;
            end
            S_G_R2: begin
                o_ctrl.rd_en     = 1'b1;
                o_ctrl.rd_addr   = DIM_W'(2);
                o_ctrl.row_shift = 1'b1;
                n_state          = S_G_LOAD;
            end
            S_G_LOAD: begin
                o_ctrl.row_shift = 1'b1;
                n_col_cnt        = '0;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                // step k updates column k+1, interior only up to cols-2
                o_ctrl.scan = 1'b1;
                o_ctrl.upd  = (r_col_cnt + DIM_W'(3) <= i_eff_cols);
                if (r_col_cnt == DIM_W'(MAX_COLS - 1)) begin
                    n_state = S_G_WRITE;
                end else begin
                    n_col_cnt = r_col_cnt + DIM_W'(1);
                end
            end
            S_G_WRITE: begin
                o_ctrl.wr_en   = 1'b1;
                o_ctrl.wr_addr = r_cnt;
                o_ctrl.wr_src  = WR_ROW;
                if (r_cnt + DIM_W'(2) < i_eff_rows) begin
                    o_ctrl.rd_en   = 1'b1;
                    o_ctrl.rd_addr = r_cnt + DIM_W'(2);
                    n_cnt          = r_cnt + DIM_W'(1);
                    n_state        = S_G_LOAD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_col_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_col_cnt <= n_col_cnt;
        end
        r_cmd      <= n_cmd;
        r_row      <= n_row;
        r_col      <= n_col;
        r_value    <= n_value;
        r_res_kind <= n_res_kind;
        r_res_err  <= n_res_err;
    end

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.wr_en && o_ctrl.rd_en) |-> (o_ctrl.wr_addr != o_ctrl.rd_addr))
        else $error("row read and write hit the same address");

    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.out_load |-> !i_stat.out_busy)
        else $error("result loaded over a pending result");

    a_full_rotation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_G_WRITE) |-> (r_col_cnt == DIM_W'(MAX_COLS - 1)))
        else $error("row written back before a full rotation");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> !o_s_ready)
        else $error("second request taken while one is in work");

    a_cell_write_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.wr_en && o_ctrl.wr_src == WR_CELL) |-> (r_cmd == CMD_WRITE))
        else $error("cell write without a write request");

endmodule

/* hdl/lge_datapath.sv */
module lge_datapath
    import lge_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_ctrl i_ctrl,
    output t_dp_stat o_stat,
    input  logic     i_m_ready,
    output logic     o_m_valid,
    output logic     o_cell_value,
    output logic     o_range_error
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rd_data;
    logic [MAX_COLS-1:0] r_above;
    logic [MAX_COLS-1:0] r_here;
    logic [MAX_COLS-1:0] r_below;
    logic [MAX_COLS-1:0] r_new;
    logic                r_out_valid;
    logic                r_out_cell;
    logic                r_out_err;

    logic [RW-1:0]       rd_idx;
    logic [RW-1:0]       wr_idx;
    logic [DIM_W-1:0]    col_ext;
    logic [CW-1:0]       col_idx;
    logic [MAX_COLS-1:0] cell_row;
    logic [MAX_COLS-1:0] new_mod;
    logic [MAX_COLS-1:0] wr_data;
    logic [3:0]          nbr_cnt;
    logic                alive;
    logic                res_cell;

    assign rd_idx  = i_ctrl.rd_addr[RW-1:0];
    assign wr_idx  = i_ctrl.wr_addr[RW-1:0];
    assign col_ext = DIM_W'(i_ctrl.col);
    assign col_idx = col_ext[CW-1:0];

    // window sits at bits 0..2 of the rotating row buffers
    assign nbr_cnt = 4'(r_above[0]) + 4'(r_above[1]) + 4'(r_above[2])
                   + 4'(r_here[0])  + 4'(r_here[2])
                   + 4'(r_below[0]) + 4'(r_below[1]) + 4'(r_below[2]);
    assign alive   = (nbr_cnt == 4'd3) || (r_here[1] && nbr_cnt == 4'd2);

    always_comb begin
        cell_row          = r_rd_data;
        cell_row[col_idx] = i_ctrl.value;
        new_mod           = r_new;
        new_mod[1]        = i_ctrl.upd ? alive : r_new[1];
    end

    always_comb begin
        unique case (i_ctrl.wr_src)
            WR_CELL: wr_data = cell_row;
            WR_ROW:  wr_data = r_new;
            default: wr_data = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.res_kind)
            RES_VALUE: res_cell = i_ctrl.value;
            RES_RDBIT: res_cell = r_rd_data[col_idx];
            default:   res_cell = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.row_shift) begin
            r_above <= r_here;
            r_here  <= r_below;
            r_new   <= r_below;
            r_below <= r_rd_data;
        end else if (i_ctrl.scan) begin
            r_above <= {r_above[0], r_above[MAX_COLS-1:1]};
            r_here  <= {r_here[0], r_here[MAX_COLS-1:1]};
            r_below <= {r_below[0], r_below[MAX_COLS-1:1]};
            r_new   <= {new_mod[0], new_mod[MAX_COLS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctrl.out_load) begin
            r_out_cell <= res_cell;
            r_out_err  <= i_ctrl.out_err;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_m_ready;
    assign o_m_valid       = r_out_valid;
    assign o_cell_value    = r_out_cell;
    assign o_range_error   = r_out_err;

endmodule

/* hdl/life_generation_engine.sv */
// Life board engine, rule B3/S23, one bit per cell.
// Input stream: s_axis_tuser carries the command (write cell, advance one
// generation, read cell); s_axis_tdata carries row, column and write value.
// Output stream: one result per request, the cell value in m_axis_tdata[0]
// and the range error flag in m_axis_tuser.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data set columns (index 0)
// and rows (index 1) in use; write them only while the engine is idle.
// Requests are handled one at a time; tready is high only when idle.
// A write or read is decoded, its row read, then the result loaded; a cell
// out of range, an unused command or an advance on a board with no interior
// skips the row read and goes straight to the result. In an advance
// each interior row is read into rotating row buffers and scanned one cell
// per cycle over the full MAX_COLS width, then written back to the
// row-wide board memory.
// After reset the board memory is cleared one row per cycle, all MAX_ROWS
// rows, with tready low; configuration writes are taken meanwhile.
// The result sits in an output register; while the receiver stalls, the
// next request may already be accepted and worked on, and its result
// waits until the register is free.
module life_generation_engine
    import lge_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // row[6:0], col[14:7], value[15]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // cell_value[0], zeros above
    output logic [0:0]  m_axis_tuser    // range_error[0]
);

    logic [8:0]       r_cols_in_use;
    logic [7:0]       r_rows_in_use;
    logic [DIM_W-1:0] cols_ext;
    logic [DIM_W-1:0] rows_ext;
    logic [DIM_W-1:0] eff_cols;
    logic [DIM_W-1:0] eff_rows;
    t_dp_ctrl         dp_ctrl;
    t_dp_stat         dp_stat;
    logic             cell_value;
    logic             range_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_in_use <= COLS_RESET;
            r_rows_in_use <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COLS: r_cols_in_use <= i_cfg_data;
                REG_ROWS: r_rows_in_use <= i_cfg_data[7:0];
                default:  ;
            endcase
        end
    end

    // oversized settings clamp to the physical board
    assign cols_ext = DIM_W'(r_cols_in_use);
    assign rows_ext = DIM_W'(r_rows_in_use);
    assign eff_cols = (cols_ext > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ext;
    assign eff_rows = (rows_ext > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ext;

    lge_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_row      (s_axis_tdata[6:0]),
        .i_col      (s_axis_tdata[14:7]),
        .i_value    (s_axis_tdata[15]),
        .i_eff_cols (eff_cols),
        .i_eff_rows (eff_rows),
        .o_ctrl     (dp_ctrl),
        .i_stat     (dp_stat)
    );

    lge_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (dp_ctrl),
        .o_stat        (dp_stat),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_cell_value  (cell_value),
        .o_range_error (range_error)
    );

    assign m_axis_tdata = {7'd0, cell_value};
    assign m_axis_tuser = range_error;

endmodule
